// ===== rtl/aimd_pkg.sv =====
// Shared types, constants and helpers for the AIMD bitrate adapter.
package aimd_pkg;

    // Field widths
    localparam int VIDEO_W = 20;
    localparam int AUDIO_W = 24;
    localparam int LOSS_W  = 14;
    localparam int DELAY_W = 21;

    // Stream word widths, padded to whole bytes
    localparam int IN_BITS   = VIDEO_W + AUDIO_W + LOSS_W + DELAY_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = VIDEO_W + AUDIO_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = AUDIO_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_VIDEO = 2'd0,
        CFG_MAX_VIDEO = 2'd1,
        CFG_MIN_AUDIO = 2'd2,
        CFG_MAX_AUDIO = 2'd3
    } cfg_idx_t;

    // Register reset values
    localparam logic [VIDEO_W-1:0] MIN_VIDEO_RST = 20'd64;
    localparam logic [VIDEO_W-1:0] MAX_VIDEO_RST = 20'd8192;
    localparam logic [AUDIO_W-1:0] MIN_AUDIO_RST = 24'd8000;
    localparam logic [AUDIO_W-1:0] MAX_AUDIO_RST = 24'd256000;

    // Additive steps: video max/40 (cautious step is half of it), audio max/20
    localparam int VSTEP_W = 15;
    localparam int ASTEP_W = 20;
    localparam logic [VSTEP_W-1:0] VSTEP_RST = VSTEP_W'(MAX_VIDEO_RST / 40);
    localparam logic [ASTEP_W-1:0] ASTEP_RST = ASTEP_W'(MAX_AUDIO_RST / 20);

    // Divide by 5 via reciprocal: exact for any 22-bit operand
    localparam int DIV5_IN_W  = 22;
    localparam int DIV5_OUT_W = 20;
    localparam int DIV5_SH    = 25;
    localparam logic [22:0] DIV5_MUL = 23'd6710887;  // ceil(2^25 / 5)

    // Decision thresholds
    localparam logic [LOSS_W-1:0] LOSS_CLEAR_MAX = 14'd200;
    localparam logic [LOSS_W-1:0] LOSS_CONG_MIN  = 14'd500;
    localparam logic [LOSS_W-1:0] LOSS_HEAVY_MIN = 14'd1000;
    localparam logic signed [DELAY_W-1:0] DELAY_CLEAR_MAX = -21'sd100;
    localparam logic signed [DELAY_W-1:0] DELAY_CONG_MIN  = 21'sd500;
    localparam logic signed [DELAY_W-1:0] DELAY_MID_MIN   = 21'sd1000;
    localparam logic signed [DELAY_W-1:0] DELAY_HEAVY_MIN = 21'sd5000;

    // Q16 factors
    localparam int FACT_W = 17;
    localparam logic [FACT_W-1:0] F_100 = 17'd65536;
    localparam logic [FACT_W-1:0] F_095 = 17'd62259;
    localparam logic [FACT_W-1:0] F_085 = 17'd55706;
    localparam logic [FACT_W-1:0] F_070 = 17'd45875;
    localparam logic [FACT_W-1:0] F_050 = 17'd32768;
    localparam int FRAC_W = 16;

    // Live configuration handed to the datapath
    typedef struct packed {
        logic [VIDEO_W-1:0] min_video;
        logic [VIDEO_W-1:0] max_video;
        logic [AUDIO_W-1:0] min_audio;
        logic [AUDIO_W-1:0] max_audio;
        logic [VSTEP_W-1:0] vstep;     // max_video / 40
        logic [ASTEP_W-1:0] astep;     // max_audio / 20
    } cfg_t;

    function automatic logic [DIV5_OUT_W-1:0] div5(input logic [DIV5_IN_W-1:0] x);
        logic [DIV5_IN_W+22:0] p;
        p = {23'b0, x} * {{DIV5_IN_W{1'b0}}, DIV5_MUL};
        return p[DIV5_SH +: DIV5_OUT_W];
    endfunction

endpackage

// ===== rtl/aimd_bitrate_adapter_top.sv =====
// Top level of the AIMD bitrate adapter: stream ports and three-stage datapath.
// Path from input transaction to output valid: input reg, scale reg, clamp reg.
// Throughput: one report per cycle; each stage holds under back-pressure from m_axis_tready.
// The scale stage has two constant-width multipliers (20x17 and 24x17) in parallel.
// Reset (rst_n, async low) empties the pipeline and loads the default clamp registers.
module aimd_bitrate_adapter_top
    import aimd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input report
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [19:0] video_now_kbps, [43:20] audio_now_bps, [57:44] loss_centipct,
    // [78:58] delay_trend_us, [79] zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // adapted bitrates
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [19:0] video_new_kbps, [43:20] audio_new_bps, [47:44] zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // config write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;

    aimd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ---------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or the next one
    // moves on. Ready ripples back from the output side.
    // ---------------------------------------------------------------
    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic a_ready, b_ready, c_ready;

    assign c_ready = !c_valid_reg || m_axis_tready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;

    assign s_axis_tready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready) a_valid_reg <= s_axis_tvalid;
            if (b_ready) b_valid_reg <= a_valid_reg;
            if (c_ready) c_valid_reg <= b_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage A: captured report
    // ---------------------------------------------------------------
    logic        [VIDEO_W-1:0] a_video_reg;
    logic        [AUDIO_W-1:0] a_audio_reg;
    logic        [LOSS_W-1:0]  a_loss_reg;
    logic signed [DELAY_W-1:0] a_delay_reg;

    always_ff @(posedge clk)
    begin
        if (a_ready && s_axis_tvalid)
        begin
            a_video_reg <= s_axis_tdata[0 +: VIDEO_W];
            a_audio_reg <= s_axis_tdata[VIDEO_W +: AUDIO_W];
            a_loss_reg  <= s_axis_tdata[VIDEO_W+AUDIO_W +: LOSS_W];
            a_delay_reg <= s_axis_tdata[VIDEO_W+AUDIO_W+LOSS_W +: DELAY_W];
        end
    end

    // ---------------------------------------------------------------
    // Decision and scaling. Saturating loss to 10000 and delay to
    // +/-1e6 never moves a value across a threshold, so raw inputs
    // are compared directly.
    // ---------------------------------------------------------------
    logic loss_cong, delay_cong, loss_clear, delay_clear;
    logic congested, clear_path, strong_clear;
    logic [FACT_W-1:0] loss_f, delay_f, fact;
    logic [VIDEO_W+FACT_W-1:0] prod_v;
    logic [AUDIO_W+FACT_W-1:0] prod_a;
    logic [VIDEO_W:0] sum_v, b_video_next, b_video_reg;
    logic [AUDIO_W:0] sum_a, b_audio_next, b_audio_reg;
    logic [VSTEP_W-1:0] vstep;

    assign loss_cong    = a_loss_reg > LOSS_CONG_MIN;
    assign delay_cong   = a_delay_reg > DELAY_CONG_MIN;
    assign loss_clear   = a_loss_reg <= LOSS_CLEAR_MAX;
    assign delay_clear  = a_delay_reg < DELAY_CLEAR_MAX;
    assign congested    = loss_cong || delay_cong;
    assign clear_path   = !congested && (loss_clear || delay_clear);
    assign strong_clear = loss_clear && delay_clear;

    always_comb
    begin
        if (a_loss_reg > LOSS_HEAVY_MIN) loss_f = F_070;
        else if (loss_cong)              loss_f = F_085;
        else                             loss_f = F_100;

        if (a_delay_reg > DELAY_HEAVY_MIN)    delay_f = F_050;
        else if (a_delay_reg > DELAY_MID_MIN) delay_f = F_070;
        else if (delay_cong)                  delay_f = F_095;
        else                                  delay_f = F_100;

        // neutral reports hold: factor 1.0 is exact
        if (congested) fact = (loss_f < delay_f) ? loss_f : delay_f;
        else           fact = F_100;
    end

    assign prod_v = {{FACT_W{1'b0}}, a_video_reg} * {{VIDEO_W{1'b0}}, fact};
    assign prod_a = {{FACT_W{1'b0}}, a_audio_reg} * {{AUDIO_W{1'b0}}, fact};

    // cautious step (max/80) is the strong step halved
    assign vstep = strong_clear ? cfg.vstep : (cfg.vstep >> 1);
    assign sum_v = {1'b0, a_video_reg} + (VIDEO_W+1)'(vstep);
    assign sum_a = {1'b0, a_audio_reg} + (AUDIO_W+1)'(cfg.astep);

    always_comb
    begin
        if (clear_path)
        begin
            b_video_next = sum_v;
            b_audio_next = sum_a;
        end
        else
        begin
            b_video_next = prod_v[FRAC_W +: VIDEO_W+1];
            b_audio_next = prod_a[FRAC_W +: AUDIO_W+1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_video_reg <= b_video_next;
            b_audio_reg <= b_audio_next;
        end
    end

    // ---------------------------------------------------------------
    // Clamp: cap at max first, then raise to min (min wins if inverted)
    // ---------------------------------------------------------------
    logic [VIDEO_W:0]   capped_v;
    logic [AUDIO_W:0]   capped_a;
    logic [VIDEO_W-1:0] c_video_next, c_video_reg;
    logic [AUDIO_W-1:0] c_audio_next, c_audio_reg;

    always_comb
    begin
        capped_v = (b_video_reg > {1'b0, cfg.max_video}) ? {1'b0, cfg.max_video}
                                                         : b_video_reg;
        capped_a = (b_audio_reg > {1'b0, cfg.max_audio}) ? {1'b0, cfg.max_audio}
                                                         : b_audio_reg;
        c_video_next = (capped_v < {1'b0, cfg.min_video}) ? cfg.min_video
                                                          : capped_v[VIDEO_W-1:0];
        c_audio_next = (capped_a < {1'b0, cfg.min_audio}) ? cfg.min_audio
                                                          : capped_a[AUDIO_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && b_valid_reg)
        begin
            c_video_reg <= c_video_next;
            c_audio_reg <= c_audio_next;
        end
    end

    assign m_axis_tvalid = c_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, c_audio_reg, c_video_reg};

endmodule

// ===== rtl/aimd_cfg.sv =====
// Configuration registers and precomputed additive steps.
module aimd_cfg
    import aimd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [VIDEO_W-1:0] min_video_reg, max_video_reg;
    logic [AUDIO_W-1:0] min_audio_reg, max_audio_reg;
    logic [VSTEP_W-1:0] vstep_reg;
    logic [ASTEP_W-1:0] astep_reg;

    cfg_idx_t              idx;
    logic [DIV5_IN_W-1:0]  div_in;
    logic [DIV5_OUT_W-1:0] div_out;

    assign idx = cfg_idx_t'(cfg_index);

    // one shared /5: max/40 = (max>>3)/5, max/20 = (max>>2)/5
    always_comb
    begin
        unique case (idx)
            CFG_MAX_VIDEO: div_in = DIV5_IN_W'(cfg_data[VIDEO_W-1:3]);
            CFG_MAX_AUDIO: div_in = cfg_data[AUDIO_W-1:2];
            default:       div_in = '0;
        endcase
    end

    assign div_out = div5(div_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_video_reg <= MIN_VIDEO_RST;
            max_video_reg <= MAX_VIDEO_RST;
            min_audio_reg <= MIN_AUDIO_RST;
            max_audio_reg <= MAX_AUDIO_RST;
            vstep_reg     <= VSTEP_RST;
            astep_reg     <= ASTEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (idx)
                CFG_MIN_VIDEO: min_video_reg <= cfg_data[VIDEO_W-1:0];
                CFG_MAX_VIDEO:
                begin
                    max_video_reg <= cfg_data[VIDEO_W-1:0];
                    vstep_reg     <= div_out[VSTEP_W-1:0];
                end
                CFG_MIN_AUDIO: min_audio_reg <= cfg_data;
                CFG_MAX_AUDIO:
                begin
                    max_audio_reg <= cfg_data;
                    astep_reg     <= div_out[ASTEP_W-1:0];
                end
            endcase
        end
    end

    assign cfg.min_video = min_video_reg;
    assign cfg.max_video = max_video_reg;
    assign cfg.min_audio = min_audio_reg;
    assign cfg.max_audio = max_audio_reg;
    assign cfg.vstep     = vstep_reg;
    assign cfg.astep     = astep_reg;

endmodule

// ===== rtl/aimd_checker.sv =====
// Port-level checker for the AIMD bitrate adapter, bound to the top level.
module aimd_checker
    import aimd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction changed while stalled");

    // an empty output stage means the pipeline can take a report
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready with output empty");

    // pad bits of the result word are zero
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:OUT_BITS] == '0)
        else $error("nonzero pad bits in output word");

    // output cannot go valid without a report having entered earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid, 3) || $past(s_axis_tvalid, 2)
                                 || $past(!s_axis_tready, 2) || $past(!s_axis_tready, 3)
                                 || $past(m_axis_tvalid, 2))
        else $error("result appeared without an input transaction");

endmodule

bind aimd_bitrate_adapter_top aimd_checker u_aimd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
